// ===== hw/rtl/ccc_pkg.sv =====
// Shared types and constants of the column/circle contact pipeline.
package ccc_pkg;

  // Field and datapath widths.
  localparam int RootW = 25;   // distance, floor of the square root
  localparam int RadW  = 50;   // squared distance on a hit
  localparam int QuoW  = 17;   // normal magnitude quotient
  localparam int NumW  = 43;   // divider numerator
  localparam int DenW  = 26;   // divider denominator
  localparam int HalfW = 27;   // signed half-overlap offset
  localparam int NrmW  = 18;   // normal component
  localparam int ProdW = 45;   // normal times half offset
  localparam int InW   = 208;  // input tdata width
  localparam int OutW  = 176;  // result tdata width

  // Column axis codes.
  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  // Distances at or below this many LSB count as coincident centers.
  localparam logic [RootW-1:0] NearLimit = 25'd6;
  localparam logic signed [NrmW-1:0] OneQ = 18'sd65536;

  // Per-item context that travels with the pipeline.
  typedef struct packed {
    logic signed [31:0]       ou;
    logic signed [31:0]       ov;
    logic signed [31:0]       lw;
    logic [23:0]              cr;
    logic [23:0]              orad;
    logic [24:0]              rsum;
    logic                     du_neg;
    logic                     dv_neg;
    logic [24:0]              du_mag;
    logic [24:0]              dv_mag;
    logic                     far;
    logic                     hit;
    logic [RootW-1:0]         root;
    logic signed [HalfW-1:0]  half;
    logic                     near;
    logic [24:0]              depth;
  } ctx_t;

endpackage

// ===== hw/rtl/ccc_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module ccc_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  logic [ccc_pkg::RadW-1:0]    rad_i,
  input  ccc_pkg::ctx_t               ctx_i,
  output logic                        vld_o,
  output logic [ccc_pkg::RootW-1:0]   root_o,
  output ccc_pkg::ctx_t               ctx_o
);

  localparam int N = ccc_pkg::RootW;
  localparam int RadW = ccc_pkg::RadW;

  logic [N-1:0]      vld_r;
  logic [N+1:0]      rem_r   [N];
  logic [N-1:0]      root_r  [N];
  logic [RadW-1:0]   x_r     [N];
  ccc_pkg::ctx_t     ctx_r   [N];

  logic              vld_in  [N];
  logic [N+1:0]      rem_in  [N];
  logic [N-1:0]      root_in [N];
  logic [RadW-1:0]   x_in    [N];
  ccc_pkg::ctx_t     ctx_in  [N];

  logic [N+3:0]      rem_sh  [N];
  logic [N+3:0]      trial   [N];
  logic              ge      [N];
  logic [N+1:0]      rem_nxt [N];
  logic [N-1:0]      root_nxt[N];
  logic [RadW-1:0]   x_nxt   [N];

  // Stage inputs: the first stage takes the radicand, the rest chain.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (i == 0) begin
        vld_in[i]  = vld_i;
        rem_in[i]  = '0;
        root_in[i] = '0;
        x_in[i]    = rad_i;
        ctx_in[i]  = ctx_i;
      end else begin
        vld_in[i]  = vld_r[i-1];
        rem_in[i]  = rem_r[i-1];
        root_in[i] = root_r[i-1];
        x_in[i]    = x_r[i-1];
        ctx_in[i]  = ctx_r[i-1];
      end
    end
  end

  // Each stage brings down two radicand bits and decides one root bit.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      rem_sh[i]   = {rem_in[i], x_in[i][RadW-1 -: 2]};
      trial[i]    = {2'b00, root_in[i], 2'b01};
      ge[i]       = rem_sh[i] >= trial[i];
      rem_nxt[i]  = ge[i] ? (N+2)'(rem_sh[i] - trial[i]) : rem_sh[i][N+1:0];
      root_nxt[i] = {root_in[i][N-2:0], ge[i]};
      x_nxt[i]    = {x_in[i][RadW-3:0], 2'b00};
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      for (int i = 0; i < N; i++) begin
        vld_r[i] <= vld_in[i];
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
        x_r[i]    <= x_nxt[i];
        ctx_r[i]  <= ctx_in[i];
      end
    end
  end

  assign vld_o  = vld_r[N-1];
  assign root_o = root_r[N-1];
  assign ctx_o  = ctx_r[N-1];

endmodule

// ===== hw/rtl/ccc_div.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage.
module ccc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  logic [ccc_pkg::NumW-1:0]    num_u_i,
  input  logic [ccc_pkg::NumW-1:0]    num_v_i,
  input  logic [ccc_pkg::DenW-1:0]    den_i,
  input  ccc_pkg::ctx_t               ctx_i,
  output logic                        vld_o,
  output logic [ccc_pkg::QuoW-1:0]    quo_u_o,
  output logic [ccc_pkg::QuoW-1:0]    quo_v_o,
  output ccc_pkg::ctx_t               ctx_o
);

  localparam int N  = ccc_pkg::QuoW;
  localparam int DW = ccc_pkg::DenW;
  localparam int NW = ccc_pkg::NumW;

  logic [N-1:0]     vld_r;
  logic [DW-1:0]    rem_r  [N][2];
  logic [N-1:0]     lo_r   [N][2];
  logic [N-1:0]     q_r    [N][2];
  logic [DW-1:0]    den_r  [N];
  ccc_pkg::ctx_t    ctx_r  [N];

  logic             vld_in [N];
  logic [DW-1:0]    rem_in [N][2];
  logic [N-1:0]     lo_in  [N][2];
  logic [N-1:0]     q_in   [N][2];
  logic [DW-1:0]    den_in [N];
  ccc_pkg::ctx_t    ctx_in [N];

  logic [DW:0]      sh     [N][2];
  logic             ge     [N][2];
  logic [DW-1:0]    rem_nxt[N][2];
  logic [N-1:0]     lo_nxt [N][2];
  logic [N-1:0]     q_nxt  [N][2];

  // Stage inputs: the first stage splits each numerator, the rest chain.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (i == 0) begin
        vld_in[i]    = vld_i;
        rem_in[i][0] = num_u_i[NW-1:N];
        rem_in[i][1] = num_v_i[NW-1:N];
        lo_in[i][0]  = num_u_i[N-1:0];
        lo_in[i][1]  = num_v_i[N-1:0];
        q_in[i][0]   = '0;
        q_in[i][1]   = '0;
        den_in[i]    = den_i;
        ctx_in[i]    = ctx_i;
      end else begin
        vld_in[i]    = vld_r[i-1];
        rem_in[i][0] = rem_r[i-1][0];
        rem_in[i][1] = rem_r[i-1][1];
        lo_in[i][0]  = lo_r[i-1][0];
        lo_in[i][1]  = lo_r[i-1][1];
        q_in[i][0]   = q_r[i-1][0];
        q_in[i][1]   = q_r[i-1][1];
        den_in[i]    = den_r[i-1];
        ctx_in[i]    = ctx_r[i-1];
      end
    end
  end

  // Shift in the next numerator bit and subtract the divisor when it fits.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int l = 0; l < 2; l++) begin
        sh[i][l]      = {rem_in[i][l], lo_in[i][l][N-1]};
        ge[i][l]      = sh[i][l] >= {1'b0, den_in[i]};
        rem_nxt[i][l] = ge[i][l] ? DW'(sh[i][l] - {1'b0, den_in[i]}) : sh[i][l][DW-1:0];
        lo_nxt[i][l]  = {lo_in[i][l][N-2:0], 1'b0};
        q_nxt[i][l]   = {q_in[i][l][N-2:0], ge[i][l]};
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      for (int i = 0; i < N; i++) begin
        vld_r[i] <= vld_in[i];
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        for (int l = 0; l < 2; l++) begin
          rem_r[i][l] <= rem_nxt[i][l];
          lo_r[i][l]  <= lo_nxt[i][l];
          q_r[i][l]   <= q_nxt[i][l];
        end
        den_r[i] <= den_in[i];
        ctx_r[i] <= ctx_in[i];
      end
    end
  end

  assign vld_o   = vld_r[N-1];
  assign quo_u_o = q_r[N-1][0];
  assign quo_v_o = q_r[N-1][1];
  assign ctx_o   = ctx_r[N-1];

endmodule

// ===== hw/rtl/column_circle_contact_top.sv =====
// Top level of the column/circle contact pipeline.
//
// Channel  Direction  Handshake              Payload
// in_      input      in_tvalid/in_tready    in_tdata: column and other circle, radii, axis pos
// out_     output     out_tvalid/out_tready  out_tdata: normal, contact point, depth; tuser: hit
// cfg_     input      cfg_wr_en              cfg_wr_data: column axis
//
// One item enters per cycle while the output is not stalled; each item passes 49
// register stages before its result is offered. Most of the depth comes from the
// 25-stage square root and the 17-stage divider.
// Reset clears all stage valid bits and sets the column axis to z.
// A stalled output freezes the whole pipeline; in_tready is low only then.
module column_circle_contact_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // column_u, column_v, other_u, other_v, column_radius, other_radius,
  // lengthwise_position
  input  logic [ccc_pkg::InW-1:0]    in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // normal_x, normal_y, normal_z, pos_x, pos_y, pos_z, depth, zero pad
  output logic [ccc_pkg::OutW-1:0]   out_tdata,
  // hit
  output logic                       out_tuser,
  input  logic                       cfg_wr_en,
  input  logic [1:0]                 cfg_wr_data
);

  localparam int RootW = ccc_pkg::RootW;
  localparam int NrmW  = ccc_pkg::NrmW;
  localparam int ProdW = ccc_pkg::ProdW;
  localparam int HalfW = ccc_pkg::HalfW;

  logic                      en;
  logic [1:0]                axis_r;

  logic                      s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r;
  ccc_pkg::ctx_t             s1_ctx_r, s2_ctx_r, s3_ctx_r, s4_ctx_r, s5_ctx_r, s6_ctx_r;
  ccc_pkg::ctx_t             s1_ctx_nxt, s3_ctx_nxt, s4_ctx_nxt;
  logic [49:0]               sq_u_r, sq_v_r, rs2_r;
  logic [ccc_pkg::RadW-1:0]  rad_r;
  logic [ccc_pkg::NumW-1:0]  num_u_r, num_v_r;
  logic [ccc_pkg::DenW-1:0]  den_r;
  logic signed [NrmW-1:0]    nu_r, nv_r, nu_nxt, nv_nxt;
  logic signed [NrmW-1:0]    nu6_r, nv6_r;
  logic signed [ProdW-1:0]   pu_r, pv_r;

  logic                      sq_vld;
  logic [RootW-1:0]          sq_root;
  ccc_pkg::ctx_t             sq_ctx;
  logic                      dv_vld;
  logic [ccc_pkg::QuoW-1:0]  quo_u, quo_v;
  ccc_pkg::ctx_t             dv_ctx;

  logic signed [31:0]        f_cu, f_cv, f_ou, f_ov, f_lw;
  logic [23:0]               f_cr, f_or;
  logic signed [32:0]        du_w, dv_w;
  logic [32:0]               du_abs, dv_abs;
  logic [50:0]               d2_w;
  logic signed [HalfW-1:0]   h_w;
  logic [HalfW-2:0]          hm_w, hq_w;
  logic signed [NrmW-1:0]    qu_s, qv_s;
  logic [31:0]               pa_w, pb_w;

  logic                      out_tvalid_r, hit_r;
  logic [NrmW-1:0]           nx_r, ny_r, nz_r, nx_nxt, ny_nxt, nz_nxt;
  logic [31:0]               px_r, py_r, pz_r, px_nxt, py_nxt, pz_nxt;
  logic [24:0]               depth_r;

  // Round a normal-times-offset product to Q16.16, add the center, saturate.
  function automatic logic [31:0] place(input logic signed [ProdW-1:0] p,
                                        input logic signed [31:0] o);
    logic [ProdW-1:0]   m;
    logic [28:0]        r;
    logic signed [33:0] s;
    m = p[ProdW-1] ? ProdW'(-p) : p;
    r = 29'((m + ProdW'(32768)) >> 16);
    s = p[ProdW-1] ? -$signed({5'b0, r}) : $signed({5'b0, r});
    s = s + $signed({{2{o[31]}}, o});
    if (s > 34'sd2147483647) begin
      place = 32'h7fff_ffff;
    end else if (s < -34'sd2147483648) begin
      place = 32'h8000_0000;
    end else begin
      place = s[31:0];
    end
  endfunction

  // The whole pipeline advances unless the output holds an untaken item.
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // Column axis register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= ccc_pkg::AxisZ;
    end else if (cfg_wr_en) begin
      axis_r <= cfg_wr_data;
    end
  end

  // Stage 1: center differences, magnitudes, far test, radius sum.
  always_comb begin
    f_cu   = in_tdata[31:0];
    f_cv   = in_tdata[63:32];
    f_ou   = in_tdata[95:64];
    f_ov   = in_tdata[127:96];
    f_cr   = in_tdata[151:128];
    f_or   = in_tdata[175:152];
    f_lw   = in_tdata[207:176];
    du_w   = {f_cu[31], f_cu} - {f_ou[31], f_ou};
    dv_w   = {f_cv[31], f_cv} - {f_ov[31], f_ov};
    du_abs = du_w[32] ? 33'(-du_w) : du_w;
    dv_abs = dv_w[32] ? 33'(-dv_w) : dv_w;
    s1_ctx_nxt        = '0;
    s1_ctx_nxt.ou     = f_ou;
    s1_ctx_nxt.ov     = f_ov;
    s1_ctx_nxt.lw     = f_lw;
    s1_ctx_nxt.cr     = f_cr;
    s1_ctx_nxt.orad   = f_or;
    s1_ctx_nxt.rsum   = {1'b0, f_cr} + {1'b0, f_or};
    s1_ctx_nxt.du_neg = du_w[32];
    s1_ctx_nxt.dv_neg = dv_w[32];
    s1_ctx_nxt.du_mag = du_abs[24:0];
    s1_ctx_nxt.dv_mag = dv_abs[24:0];
    s1_ctx_nxt.far    = (|du_abs[32:25]) || (|dv_abs[32:25]);
  end

  // Stage 3 combinational part: squared distance and overlap test.
  always_comb begin
    d2_w           = {1'b0, sq_u_r} + {1'b0, sq_v_r};
    s3_ctx_nxt     = s2_ctx_r;
    s3_ctx_nxt.hit = !s2_ctx_r.far && (d2_w < {1'b0, rs2_r});
  end

  // Stage 4 combinational part: half offset, near test, divider operands.
  always_comb begin
    h_w  = $signed({2'b00, sq_root}) + $signed({3'b000, sq_ctx.orad})
         - $signed({3'b000, sq_ctx.cr});
    hm_w = h_w[HalfW-1] ? (HalfW-1)'(-h_w) : h_w[HalfW-2:0];
    hq_w = (HalfW-1)'(({1'b0, hm_w} + HalfW'(1)) >> 1);
    s4_ctx_nxt       = sq_ctx;
    s4_ctx_nxt.root  = sq_root;
    s4_ctx_nxt.half  = h_w[HalfW-1] ? -$signed({1'b0, hq_w}) : $signed({1'b0, hq_w});
    s4_ctx_nxt.near  = sq_root <= ccc_pkg::NearLimit;
    s4_ctx_nxt.depth = sq_ctx.rsum - sq_root;
  end

  // Stage 5 combinational part: signed normal with the coincident override.
  always_comb begin
    qu_s = $signed({1'b0, quo_u});
    qv_s = $signed({1'b0, quo_v});
    if (dv_ctx.near) begin
      nu_nxt = ccc_pkg::OneQ;
      nv_nxt = '0;
    end else begin
      nu_nxt = dv_ctx.du_neg ? -qu_s : qu_s;
      nv_nxt = dv_ctx.dv_neg ? -qv_s : qv_s;
    end
  end

  // Front stages and the stages around the square root and divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= sq_vld;
      s5_vld_r <= dv_vld;
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ctx_r <= s1_ctx_nxt;
      sq_u_r   <= s1_ctx_r.du_mag * s1_ctx_r.du_mag;
      sq_v_r   <= s1_ctx_r.dv_mag * s1_ctx_r.dv_mag;
      rs2_r    <= s1_ctx_r.rsum * s1_ctx_r.rsum;
      s2_ctx_r <= s1_ctx_r;
      rad_r    <= d2_w[ccc_pkg::RadW-1:0];
      s3_ctx_r <= s3_ctx_nxt;
      num_u_r  <= ccc_pkg::NumW'({sq_ctx.du_mag, 17'b0}) + ccc_pkg::NumW'(sq_root);
      num_v_r  <= ccc_pkg::NumW'({sq_ctx.dv_mag, 17'b0}) + ccc_pkg::NumW'(sq_root);
      den_r    <= {sq_root, 1'b0};
      s4_ctx_r <= s4_ctx_nxt;
      nu_r     <= nu_nxt;
      nv_r     <= nv_nxt;
      s5_ctx_r <= dv_ctx;
      pu_r     <= nu_r * $signed(s5_ctx_r.half);
      pv_r     <= nv_r * $signed(s5_ctx_r.half);
      nu6_r    <= nu_r;
      nv6_r    <= nv_r;
      s6_ctx_r <= s5_ctx_r;
    end
  end

  // Square root of the squared distance.
  ccc_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (s3_vld_r),
    .rad_i  (rad_r),
    .ctx_i  (s3_ctx_r),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .ctx_o  (sq_ctx)
  );

  // Normal magnitudes, rounded: (2*|d|*65536 + dist) / (2*dist).
  ccc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (s4_vld_r),
    .num_u_i (num_u_r),
    .num_v_i (num_v_r),
    .den_i   (den_r),
    .ctx_i   (s4_ctx_r),
    .vld_o   (dv_vld),
    .quo_u_o (quo_u),
    .quo_v_o (quo_v),
    .ctx_o   (dv_ctx)
  );

  // Stage 7 combinational part: contact point and mapping onto world axes.
  always_comb begin
    pa_w   = place(pu_r, s6_ctx_r.ou);
    pb_w   = place(pv_r, s6_ctx_r.ov);
    nx_nxt = '0;
    ny_nxt = '0;
    nz_nxt = '0;
    px_nxt = '0;
    py_nxt = '0;
    pz_nxt = '0;
    if (s6_ctx_r.hit) begin
      case (axis_r)
        ccc_pkg::AxisX: begin
          ny_nxt = nu6_r;
          nz_nxt = nv6_r;
          px_nxt = s6_ctx_r.lw;
          py_nxt = pa_w;
          pz_nxt = pb_w;
        end
        ccc_pkg::AxisY: begin
          nx_nxt = nu6_r;
          nz_nxt = nv6_r;
          px_nxt = pa_w;
          py_nxt = s6_ctx_r.lw;
          pz_nxt = pb_w;
        end
        default: begin
          nx_nxt = nu6_r;
          ny_nxt = nv6_r;
          px_nxt = pa_w;
          py_nxt = pb_w;
          pz_nxt = s6_ctx_r.lw;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r   <= s6_ctx_r.hit;
      nx_r    <= nx_nxt;
      ny_r    <= ny_nxt;
      nz_r    <= nz_nxt;
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      pz_r    <= pz_nxt;
      depth_r <= s6_ctx_r.hit ? s6_ctx_r.depth : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = hit_r;
  assign out_tdata  = {1'b0, depth_r, pz_r, py_r, px_r, nz_r, ny_r, nx_r};

  // A miss carries an all-zero payload.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss item with nonzero payload");

  // A hit always has positive depth.
  a_hit_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> depth_r != '0)
    else $error("hit item with zero depth");

  // The normal has no component along a z column.
  a_axis_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && axis_r == ccc_pkg::AxisZ |-> nz_r == '0)
    else $error("normal has a component along the column axis");

  // A waiting result holds the input side.
  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while pipeline is stalled");

endmodule

// ===== dv/tb_column_circle_contact_top.sv =====
// Self-checking testbench for the column/circle contact pipeline.
module tb_column_circle_contact_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 60;
  localparam int CycleLimit = 400000;
  localparam longint NearQ = 6;
  localparam longint OneFix = 65536;
  localparam longint FarQ = 64'd1 << 25;

  // One contact query.
  typedef struct {
    logic signed [31:0] cu, cv, ou, ov, lw;
    logic [23:0] cr, orad;
  } query_t;

  // One contact result, laid out as {tuser, tdata} from the top bit down.
  typedef struct packed {
    logic hit;
    logic [24:0] depth;
    logic signed [31:0] pz, py, px;
    logic signed [17:0] nz, ny, nx;
  } contact_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ccc_pkg::InW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ccc_pkg::OutW-1:0] out_tdata;
  logic out_tuser;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = '0;

  logic [1:0] column_axis = ccc_pkg::AxisZ;
  contact_t pending_contacts[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit gaps_on = 1'b1;

  column_circle_contact_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[column_circle_contact_top] ERROR");
      $finish;
    end
  end

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Rounded division, ties away from zero; den is positive.
  function automatic longint round_div(longint num, longint den);
    longint m = num < 0 ? -num : num;
    longint q = (m + den / 2) / den;
    if (den % 2 != 0) q = (2 * m + den) / (2 * den);
    return num < 0 ? -q : q;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Computes the contact of one query under the current column axis.
  function automatic contact_t predict_contact(query_t q);
    contact_t c = '0;
    longint du = longint'(q.cu) - longint'(q.ou);
    longint dv = longint'(q.cv) - longint'(q.ov);
    longint rsum = longint'(q.cr) + longint'(q.orad);
    longint d2, span, nu, nv, half, pu, pv;
    logic [1:0] ax = (column_axis == 2'd3) ? ccc_pkg::AxisZ : column_axis;
    if (du >= FarQ || du <= -FarQ || dv >= FarQ || dv <= -FarQ) return c;
    d2 = du * du + dv * dv;
    if (!(d2 < rsum * rsum)) return c;
    span = longint'(floor_root(longint'(d2)));
    if (span > NearQ) begin
      nu = round_div(du * OneFix, span);
      nv = round_div(dv * OneFix, span);
    end else begin
      nu = OneFix;
      nv = 0;
    end
    half = round_div(span + longint'(q.orad) - longint'(q.cr), 2);
    pu = clamp32(round_div(nu * half, OneFix) + longint'(q.ou));
    pv = clamp32(round_div(nv * half, OneFix) + longint'(q.ov));
    c.hit = 1'b1;
    c.depth = 25'(rsum - span);
    case (ax)
      ccc_pkg::AxisX: begin
        c.nx = '0; c.ny = 18'(nu); c.nz = 18'(nv);
        c.px = q.lw; c.py = 32'(pu); c.pz = 32'(pv);
      end
      ccc_pkg::AxisY: begin
        c.nx = 18'(nu); c.ny = '0; c.nz = 18'(nv);
        c.px = 32'(pu); c.py = q.lw; c.pz = 32'(pv);
      end
      default: begin
        c.nx = 18'(nu); c.ny = 18'(nv); c.nz = '0;
        c.px = 32'(pu); c.py = 32'(pv); c.pz = q.lw;
      end
    endcase
    return c;
  endfunction

  // Result side: random stalls, compared against the oldest expected contact.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 9);
        out_tready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    contact_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[174:0]};
      if (pending_contacts.size() == 0) begin
        $display("%0t: unexpected contact %h", $realtime, got);
        errors++;
      end else begin
        want = pending_contacts.pop_front();
        if (got.hit !== want.hit)
          $display("%0t: hit exp %0d got %0d", $realtime, want.hit, got.hit);
        if (got.nx !== want.nx)
          $display("%0t: normal_x exp %0d got %0d", $realtime, want.nx, got.nx);
        if (got.ny !== want.ny)
          $display("%0t: normal_y exp %0d got %0d", $realtime, want.ny, got.ny);
        if (got.nz !== want.nz)
          $display("%0t: normal_z exp %0d got %0d", $realtime, want.nz, got.nz);
        if (got.px !== want.px)
          $display("%0t: pos_x exp %0d got %0d", $realtime, want.px, got.px);
        if (got.py !== want.py)
          $display("%0t: pos_y exp %0d got %0d", $realtime, want.py, got.py);
        if (got.pz !== want.pz)
          $display("%0t: pos_z exp %0d got %0d", $realtime, want.pz, got.pz);
        if (got.depth !== want.depth)
          $display("%0t: depth exp %0d got %0d", $realtime, want.depth, got.depth);
        if (got !== want) errors++;
      end
    end
  end

  // Sends one item, with an optional idle burst before it.
  task automatic send_query(query_t q);
    int n;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 9);
      in_tvalid = 1'b0;
      repeat (n) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {q.lw, q.orad, q.cr, q.ov, q.ou, q.cv, q.cu};
    do @(posedge clk); while (!in_tready);
    pending_contacts.push_back(predict_contact(q));
  endtask

  // Drains the pipeline, then writes the column axis.
  task automatic set_axis(logic [1:0] axis);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_contacts.size() != 0) @(negedge clk);
    repeat (Latency) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = axis;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    column_axis = axis;
  endtask

  function automatic query_t make_query(logic signed [31:0] cu, logic signed [31:0] cv,
                                        logic signed [31:0] ou, logic signed [31:0] ov,
                                        logic [23:0] cr, logic [23:0] orad,
                                        logic signed [31:0] lw);
    query_t q;
    q.cu = cu; q.cv = cv; q.ou = ou; q.ov = ov;
    q.cr = cr; q.orad = orad; q.lw = lw;
    return q;
  endfunction

  // Mostly nearby circles with radii of matching scale, some pure noise.
  function automatic query_t random_query();
    query_t q;
    int s = $urandom_range(0, 26);
    logic signed [31:0] du = $signed($urandom) >>> (31 - s);
    logic signed [31:0] dv = $signed($urandom) >>> (31 - s);
    q.ou = $urandom; q.ov = $urandom; q.lw = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      q.cu = $urandom; q.cv = $urandom;
      q.cr = 24'($urandom); q.orad = 24'($urandom);
    end else begin
      q.cu = q.ou + du;
      q.cv = q.ov + dv;
      q.cr = 24'($urandom) >> (s > 23 ? 0 : 23 - s);
      q.orad = 24'($urandom) >> (s > 23 ? 0 : 23 - s);
    end
    return q;
  endfunction

  task automatic test_corner_queries();
    // Coincident centers, then within and just beyond the near distance.
    send_query(make_query(0, 0, 0, 0, 24'h10000, 24'h10000, 32'h1234));
    send_query(make_query(6, 0, 0, 0, 24'h100, 24'h0, 0));
    send_query(make_query(7, 0, 0, 0, 24'h100, 24'h0, 0));
    send_query(make_query(3, 4, 0, 0, 24'h10, 24'h10, -5));
    // Touching exactly is a miss; one LSB closer is a hit.
    send_query(make_query(32'h20000, 0, 0, 0, 24'h10000, 24'h10000, 0));
    send_query(make_query(32'h1ffff, 0, 0, 0, 24'h10000, 24'h10000, 0));
    // Far apart on either axis, and just inside the far bound.
    send_query(make_query(32'h2000000, 0, 0, 0, 24'hffffff, 24'hffffff, 0));
    send_query(make_query(0, -32'sh2000000, 0, 0, 24'hffffff, 24'hffffff, 0));
    send_query(make_query(32'h1ffffff, 0, 0, 0, 24'hffffff, 24'hffffff, 0));
    // Largest radii and extreme coordinates with saturated contact points.
    send_query(make_query(32'h7fff0000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          24'hffffff, 24'h0, 32'h7fffffff));
    send_query(make_query(32'h80010000, 32'h80000000, 32'h80000000, 32'h80000000,
                          24'hffffff, 24'h0, 32'h80000000));
    send_query(make_query(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                          24'hffffff, 24'hffffff, 32'hffffffff));
    send_query(make_query(32'h7fffffff, 32'h80000000, 32'h7ffffff0, 32'h80000010,
                          24'h0, 24'hffffff, 0));
    // Wrapped differences are far apart.
    send_query(make_query(32'h7fffffff, 0, 32'h80000000, 0, 24'hffffff, 24'hffffff, 0));
    // Diagonal normals with negative components, odd distances for rounding ties.
    send_query(make_query(5, -5, 0, 0, 24'h30, 24'h0, 1));
    send_query(make_query(-32'sh30000, 32'sh40000, 0, 0, 24'h30000, 24'h30001, 0));
    send_query(make_query(-32'sh30001, -32'sh40001, 0, 0, 24'h50000, 24'h1, 0));
    send_query(make_query(0, 0, 0, 0, 24'h0, 24'h1, 0));
    send_query(make_query(0, 0, 0, 0, 24'h0, 24'h0, 0));
  endtask

  task automatic test_axis_settings();
    logic [1:0] axes[4] = '{ccc_pkg::AxisX, ccc_pkg::AxisY, 2'd3, ccc_pkg::AxisZ};
    foreach (axes[i]) begin
      set_axis(axes[i]);
      repeat (50) send_query(random_query());
      send_query(make_query(32'h7fff0000, 1, 32'h7fffffff, 0, 24'hffffff, 24'h0, -1));
    end
  endtask

  task automatic test_random_queries();
    repeat (800) send_query(random_query());
  endtask

  task automatic test_back_to_back();
    set_axis(2'($urandom_range(0, 3)));
    gaps_on = 1'b0;
    repeat (100) send_query(random_query());
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_corner_queries();
    test_axis_settings();
    test_random_queries();
    test_back_to_back();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_contacts.size() != 0) @(negedge clk);
    repeat (Latency) @(negedge clk);
    if (errors == 0) begin
      $display("[column_circle_contact_top] OK");
    end else begin
      $display("[column_circle_contact_top] ERROR");
    end
    $finish;
  end
endmodule
